FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the pump supervisor RTL.
// Included by files that carry concurrent checks; bodies vanish under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define PPSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// ante at one edge requires cons at the same edge
`define PPSS_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define PPSS_ASSERT(label, clk, rst, prop, msg)
`define PPSS_IMPLY(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/ppss_pkg.sv
// Package for the pump supervisor: register codes, reset defaults, shared types.
// No dependencies; used by ppss_core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ppss_pkg;

   localparam int BEEP_STEPS_DEF = 6;
   localparam int TIME_BITS_DEF  = 32;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEBOUNCE     = 3'd0,
      CSR_BLINK_HALF   = 3'd1,
      CSR_MAX_ON       = 3'd2,
      CSR_ALARM_IVL    = 3'd3,
      CSR_FIRST_BEEP   = 3'd4,
      CSR_BEEP_STEP    = 3'd5
   } csr_index_type;

   localparam logic [15:0] DEBOUNCE_RST    = 16'd50;
   localparam logic [15:0] BLINK_HALF_RST  = 16'd1000;
   localparam logic [31:0] MAX_ON_RST      = 32'd1800000;
   localparam logic [15:0] ALARM_IVL_RST   = 16'd5000;
   localparam logic [31:0] FIRST_BEEP_RST  = 32'd60000;
   localparam logic [15:0] BEEP_STEP_RST   = 16'd5000;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] blink_half_period_ms;
      logic [31:0] max_on_ms;
      logic [15:0] alarm_interval_ms;
      logic [31:0] first_beep_ms;
      logic [15:0] beep_step_ms;
   } cfg_type;

   typedef struct packed {
      logic button_pressed;
      logic switch_active;
      logic pump_running;
   } req_type;

   typedef struct packed {
      logic       relay_on;
      logic       switch_led;
      logic       pump_led;
      logic       rising_tone;
      logic       falling_tone;
      logic       warning_beep;
      logic       alarm_beep;
      logic       alarm_active;
      logic [2:0] beep_count;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ppss_core.sv
// Per-tick supervisor logic: time count, relay toggle, LED blink, tones,
// warning beeps and alarm. Holds all supervisor state. Depends on ppss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppss_core #(
   parameter int BEEP_STEPS = ppss_pkg::BEEP_STEPS_DEF,
   parameter int TIME_BITS  = ppss_pkg::TIME_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire ppss_pkg::req_type req,
   input  wire ppss_pkg::cfg_type cfg,
   output ppss_pkg::rsp_type      rsp
);
   import ppss_pkg::*;

   localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam logic [2:0] STEPS = 3'(BEEP_STEPS);

   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] toggle_time_ff, toggle_time_in;
   logic [TIME_BITS-1:0] en_start_ff, en_start_in;
   logic [TIME_BITS-1:0] sw_blink_ff, sw_blink_in;
   logic [TIME_BITS-1:0] pump_blink_ff, pump_blink_in;
   logic [TIME_BITS-1:0] pump_start_ff, pump_start_in;
   logic [TIME_BITS-1:0] alarm_time_ff, alarm_time_in;
   logic                 enable_ff, enable_in;
   logic                 sw_led_ff, sw_led_in;
   logic                 pump_led_ff, pump_led_in;
   logic                 seen_ff, seen_in;
   logic                 alarm_ff, alarm_in;
   logic [2:0]           bidx_ff, bidx_in;

   logic                 toggle;
   logic [18:0]          beep_dec;
   logic [CMP_BITS-1:0]  beep_thr;
   logic                 rising, falling, warn, abeep;
   logic                 level_any;

   always_comb begin
      logic [2:0] bidx_mid;
      now_in         = TIME_BITS'(now_ff + 1'b1);
      toggle_time_in = toggle_time_ff;
      en_start_in    = en_start_ff;
      sw_blink_in    = sw_blink_ff;
      pump_blink_in  = pump_blink_ff;
      pump_start_in  = pump_start_ff;
      alarm_time_in  = alarm_time_ff;
      enable_in      = enable_ff;
      sw_led_in      = sw_led_ff;
      pump_led_in    = pump_led_ff;
      seen_in        = seen_ff;
      alarm_in       = alarm_ff;
      bidx_mid       = bidx_ff;
      rising         = 1'b0;
      falling        = 1'b0;
      warn           = 1'b0;
      abeep          = 1'b0;
      level_any      = req.switch_active | req.pump_running;

      // button toggle
      toggle = req.button_pressed &&
               (CMP_BITS'(TIME_BITS'(now_in - toggle_time_ff)) > CMP_BITS'(cfg.debounce_ms));
      if (toggle) begin
         toggle_time_in = now_in;
         enable_in      = !enable_ff;
         if (!enable_ff) begin
            en_start_in = now_in;
         end else begin
            seen_in = 1'b0;
         end
         bidx_mid = 3'd0;
         alarm_in = 1'b0;
      end

      // switch LED: steady when active, blinking otherwise
      if (req.switch_active) begin
         sw_led_in = 1'b1;
      end else if (CMP_BITS'(TIME_BITS'(now_in - sw_blink_ff)) >=
                   CMP_BITS'(cfg.blink_half_period_ms)) begin
         sw_blink_in = now_in;
         sw_led_in   = !sw_led_ff;
      end

      // pump edges and LED
      if (req.pump_running) begin
         if (!seen_in) begin
            seen_in       = 1'b1;
            pump_start_in = now_in;
            rising        = 1'b1;
         end
         pump_led_in = 1'b1;
      end else begin
         if (seen_in) begin
            seen_in = 1'b0;
            falling = 1'b1;
         end
         if (CMP_BITS'(TIME_BITS'(now_in - pump_blink_ff)) >=
             CMP_BITS'(cfg.blink_half_period_ms)) begin
            pump_blink_in = now_in;
            pump_led_in   = !pump_led_ff;
         end
         bidx_mid = 3'd0;
         alarm_in = 1'b0;
      end

      // warning beep threshold, saturating at zero
      beep_dec = 19'(bidx_mid) * 19'(cfg.beep_step_ms);
      beep_thr = (32'(beep_dec) >= cfg.first_beep_ms) ? '0 :
                 CMP_BITS'(cfg.first_beep_ms - 32'(beep_dec));

      bidx_in = bidx_mid;
      if (seen_in && (bidx_mid < STEPS) &&
          (CMP_BITS'(TIME_BITS'(now_in - pump_start_in)) >= beep_thr)) begin
         warn    = 1'b1;
         bidx_in = 3'(bidx_mid + 3'd1);
         if (bidx_in == STEPS) begin
            enable_in = 1'b0;
            if (level_any) alarm_in = 1'b1;
         end
      end

      // maximum on time
      if (enable_in && (CMP_BITS'(TIME_BITS'(now_in - en_start_in)) >=
                        CMP_BITS'(cfg.max_on_ms))) begin
         enable_in = 1'b0;
         if (level_any) alarm_in = 1'b1;
      end

      if (alarm_in && (CMP_BITS'(TIME_BITS'(now_in - alarm_time_ff)) >=
                       CMP_BITS'(cfg.alarm_interval_ms))) begin
         abeep         = 1'b1;
         alarm_time_in = now_in;
      end
   end

   always_comb begin
      rsp.relay_on     = enable_in;
      rsp.switch_led   = sw_led_in;
      rsp.pump_led     = pump_led_in;
      rsp.rising_tone  = rising;
      rsp.falling_tone = falling;
      rsp.warning_beep = warn;
      rsp.alarm_beep   = abeep;
      rsp.alarm_active = alarm_in;
      rsp.beep_count   = bidx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff         <= '0;
         toggle_time_ff <= '0;
         en_start_ff    <= '0;
         sw_blink_ff    <= '0;
         pump_blink_ff  <= '0;
         pump_start_ff  <= '0;
         alarm_time_ff  <= '0;
         enable_ff      <= 1'b0;
         sw_led_ff      <= 1'b0;
         pump_led_ff    <= 1'b0;
         seen_ff        <= 1'b0;
         alarm_ff       <= 1'b0;
         bidx_ff        <= 3'd0;
      end else if (step) begin
         now_ff         <= now_in;
         toggle_time_ff <= toggle_time_in;
         en_start_ff    <= en_start_in;
         sw_blink_ff    <= sw_blink_in;
         pump_blink_ff  <= pump_blink_in;
         pump_start_ff  <= pump_start_in;
         alarm_time_ff  <= alarm_time_in;
         enable_ff      <= enable_in;
         sw_led_ff      <= sw_led_in;
         pump_led_ff    <= pump_led_in;
         seen_ff        <= seen_in;
         alarm_ff       <= alarm_in;
         bidx_ff        <= bidx_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/pump_pressure_switch_supervisor.sv
// Pump supervisor top: stream ports, register file, input and result registers.
// Depends on ppss_pkg, ppss_core and assert_macros.svh.
// An accepted request waits in the input register until the result register is free or
// being taken, then passes through ppss_core into it; a low rsp_tready holds the result there.
// Throughput: one request per cycle while rsp_tready is high; the state update is a
// single pass of compare logic in ppss_core, so a tick may follow in the next cycle.
// Reset (synchronous, active high) clears the valid flags and core state and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pump_pressure_switch_supervisor #(
   parameter int BEEP_STEPS = ppss_pkg::BEEP_STEPS_DEF,
   parameter int TIME_BITS  = ppss_pkg::TIME_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // req_tdata: [0] button_pressed, [1] switch_active, [2] pump_running, [7:3] zero
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   input  wire logic [7:0]                           req_tdata,
   // rsp_tdata: [0] relay_on, [1] switch_led, [2] pump_led, [3] rising_tone,
   // [4] falling_tone, [5] warning_beep, [6] alarm_beep, [7] alarm_active,
   // [10:8] beep_count, [15:11] zero
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output      logic [15:0]                          rsp_tdata,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [ppss_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [ppss_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import ppss_pkg::*;

   localparam logic [2:0] STEPS = 3'(BEEP_STEPS);

   cfg_type cfg_ff, cfg_in;
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type core_rsp;
   logic    advance, fire;

   // register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE:   cfg_in.debounce_ms          = csr_data[15:0];
            CSR_BLINK_HALF: cfg_in.blink_half_period_ms = csr_data[15:0];
            CSR_MAX_ON:     cfg_in.max_on_ms            = csr_data;
            CSR_ALARM_IVL:  cfg_in.alarm_interval_ms    = csr_data[15:0];
            CSR_FIRST_BEEP: cfg_in.first_beep_ms        = csr_data;
            CSR_BEEP_STEP:  cfg_in.beep_step_ms         = csr_data[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms          <= DEBOUNCE_RST;
         cfg_ff.blink_half_period_ms <= BLINK_HALF_RST;
         cfg_ff.max_on_ms            <= MAX_ON_RST;
         cfg_ff.alarm_interval_ms    <= ALARM_IVL_RST;
         cfg_ff.first_beep_ms        <= FIRST_BEEP_RST;
         cfg_ff.beep_step_ms         <= BEEP_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // two-stage pipe: input register, then result register
   assign advance      = !out_valid_ff || rsp_tready;
   assign fire         = in_valid_ff && advance;
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff.button_pressed <= req_tdata[0];
         in_data_ff.switch_active  <= req_tdata[1];
         in_data_ff.pump_running   <= req_tdata[2];
      end
      if (fire) begin
         out_data_ff <= core_rsp;
      end
   end

   ppss_core #(
      .BEEP_STEPS (BEEP_STEPS),
      .TIME_BITS  (TIME_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (fire),
      .req   (in_data_ff),
      .cfg   (cfg_ff),
      .rsp   (core_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0,
                        out_data_ff.beep_count,
                        out_data_ff.alarm_active,
                        out_data_ff.alarm_beep,
                        out_data_ff.warning_beep,
                        out_data_ff.falling_tone,
                        out_data_ff.rising_tone,
                        out_data_ff.pump_led,
                        out_data_ff.switch_led,
                        out_data_ff.relay_on};

   `PPSS_IMPLY(a_tones_exclusive, clock, reset, fire, !(core_rsp.rising_tone && core_rsp.falling_tone), "rising and falling tone in one tick")
   `PPSS_IMPLY(a_abeep_latched, clock, reset, fire && core_rsp.alarm_beep, core_rsp.alarm_active, "alarm beep without latched alarm")
   `PPSS_IMPLY(a_warn_counts, clock, reset, fire && core_rsp.warning_beep, core_rsp.beep_count != 3'd0, "warning beep with zero count")
   `PPSS_IMPLY(a_count_bound, clock, reset, fire, core_rsp.beep_count <= STEPS, "beep count past last step")
   `PPSS_IMPLY(a_result_loaded, clock, reset, fire, ##1 out_valid_ff, "fired tick left no result")

endmodule

`default_nettype wire
